// File: hw/rtl/bcb_pkg.sv
// Shared types, constants and arithmetic helpers of the background color blend unit.
// No dependencies; every other file of the block imports this package.
package bcb_pkg;

    localparam int FRONT_STAGES = 3;
    localparam int DIV_STAGES  = 6;
    localparam int DIV_BITS    = 3;
    localparam int DIV_W       = DIV_STAGES * DIV_BITS;
    // Total number of register stages from input to output.
    localparam int NUM_STAGES  = FRONT_STAGES + DIV_STAGES + 1;

    // ceil(2^32 / 255): exact floor(x / 255) for every x below 2^24 that occurs here.
    localparam logic [24:0] RECIP_255 = 25'h1010102;

    typedef enum logic [3:0] {
        MODE_NONE     = 4'd0,
        MODE_SET      = 4'd1,
        MODE_MULTIPLY = 4'd2,
        MODE_LIGHTEN  = 4'd3,
        MODE_DARKEN   = 4'd4,
        MODE_SCREEN   = 4'd5,
        MODE_DODGE    = 4'd6,
        MODE_CBURN    = 4'd7,
        MODE_ADD      = 4'd8,
        MODE_ADDA     = 4'd9,
        MODE_BURN     = 4'd10,
        MODE_OVERLAY  = 4'd11,
        MODE_ALPHA    = 4'd12,
        MODE_DEFAULT  = 4'd13
    } mode_t;

    // How the final stage forms a channel from the divider output.
    typedef enum logic [1:0] {
        KIND_DIRECT,
        KIND_DODGE,
        KIND_CBURN,
        KIND_ALPHA
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  direct;
        logic [7:0]  den;
        logic [7:0]  rem;
        logic [DIV_W-1:0] nq;
    } chan_div_t;

    typedef struct packed {
        chan_div_t [2:0] ch;
        logic [7:0]      alpha;
    } pix_div_t;

    // Load enables of the pipeline stages, by section.
    typedef struct packed {
        logic [FRONT_STAGES-1:0] front;
        logic [DIV_STAGES-1:0]   div;
        logic                    back;
    } bcb_adv_t;

    function automatic logic [15:0] div255(input logic [23:0] x);
        logic [48:0] prod;
        prod = {25'd0, x} * {24'd0, RECIP_255};
        return prod[47:32];
    endfunction

    // DIV_BITS steps of restoring division; numerator bits leave the top of nq
    // while quotient bits enter at the bottom.
    function automatic chan_div_t div_step(input chan_div_t s);
        chan_div_t  r;
        logic [8:0] part;
        r = s;
        for (int i = 0; i < DIV_BITS; i++) begin
            part = {r.rem, r.nq[DIV_W-1]};
            if (part >= {1'b0, r.den}) begin
                part = part - {1'b0, r.den};
                r.nq = {r.nq[DIV_W-2:0], 1'b1};
            end
            else begin
                r.nq = {r.nq[DIV_W-2:0], 1'b0};
            end
            r.rem = part[7:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/bcb_front.sv
// Front section: mode decode, products and divide-by-255 over three register stages.
// Depends on bcb_pkg; feeds the divider section.
module bcb_front (
    input  logic             clk,
    input  bcb_pkg::bcb_adv_t adv,
    input  logic [3:0]       default_mode,
    input  logic [3:0]       opcode,
    input  logic [7:0]       blend_alpha,
    input  logic [7:0]       old_red,
    input  logic [7:0]       old_green,
    input  logic [7:0]       old_blue,
    input  logic [7:0]       old_alpha,
    input  logic [7:0]       new_red,
    input  logic [7:0]       new_green,
    input  logic [7:0]       new_blue,
    output bcb_pkg::pix_div_t div_in
);
    import bcb_pkg::*;

    // Stage A
    mode_t             mode_a_reg, mode_a_next;
    logic [7:0]        a_a_reg;
    logic [7:0]        oa_a_reg;
    logic [15:0]       t_a_reg, t_a_next;
    logic [2:0][7:0]   o_a_reg, n_a_reg;
    logic [2:0][16:0]  prod_a_reg, prod_a_next;
    logic [2:0][15:0]  an_a_reg, an_a_next;

    // Stage B
    mode_t             mode_b_reg;
    logic [7:0]        oa_b_reg, ca_b_next, ca_b_reg;
    logic [2:0][7:0]   o_b_reg, n_b_reg;
    logic [2:0][8:0]   q1_b_reg, q1_b_next;
    logic [2:0][23:0]  ot_b_reg, ot_b_next;
    logic [2:0][15:0]  an_b_reg;

    // Stage C
    pix_div_t          div_in_reg, div_in_next;

    logic [2:0][7:0]   o_in, n_in;

    assign o_in = {old_blue, old_green, old_red};
    assign n_in = {new_blue, new_green, new_red};

    always_comb
    begin
        logic [3:0] raw;
        logic [8:0] x;
        logic [7:0] y;
        logic [7:0] w;
        raw = (opcode == MODE_DEFAULT) ? default_mode : opcode;
        case (raw)
            MODE_SET:      mode_a_next = MODE_SET;
            MODE_MULTIPLY: mode_a_next = MODE_MULTIPLY;
            MODE_LIGHTEN:  mode_a_next = MODE_LIGHTEN;
            MODE_DARKEN:   mode_a_next = MODE_DARKEN;
            MODE_SCREEN:   mode_a_next = MODE_SCREEN;
            MODE_DODGE:    mode_a_next = MODE_DODGE;
            MODE_CBURN:    mode_a_next = MODE_CBURN;
            MODE_ADD:      mode_a_next = MODE_ADD;
            MODE_ADDA:     mode_a_next = MODE_ADDA;
            MODE_BURN:     mode_a_next = MODE_BURN;
            MODE_OVERLAY:  mode_a_next = MODE_OVERLAY;
            MODE_ALPHA:    mode_a_next = MODE_ALPHA;
            default:       mode_a_next = MODE_NONE;
        endcase
        w = 8'd255 - blend_alpha;
        t_a_next = {8'd0, old_alpha} * {8'd0, w};
        for (int c = 0; c < 3; c++) begin
            case (mode_a_next)
                MODE_MULTIPLY: begin
                    x = {1'b0, n_in[c]};
                    y = o_in[c];
                end
                MODE_SCREEN: begin
                    x = {1'b0, 8'd255 - n_in[c]};
                    y = 8'd255 - o_in[c];
                end
                MODE_ADDA: begin
                    x = {1'b0, n_in[c]};
                    y = blend_alpha;
                end
                MODE_OVERLAY: begin
                    if (n_in[c] <= 8'd128) begin
                        x = {n_in[c], 1'b0};
                        y = o_in[c];
                    end
                    else begin
                        x = {8'd255 - n_in[c], 1'b0};
                        y = 8'd255 - o_in[c];
                    end
                end
                default: begin
                    x = 9'd0;
                    y = 8'd0;
                end
            endcase
            prod_a_next[c] = {8'd0, x} * {9'd0, y};
            an_a_next[c]   = {8'd0, n_in[c]} * {8'd0, blend_alpha};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.front[0])
        begin
            mode_a_reg <= mode_a_next;
            a_a_reg    <= blend_alpha;
            oa_a_reg   <= old_alpha;
            t_a_reg    <= t_a_next;
            o_a_reg    <= o_in;
            n_a_reg    <= n_in;
            prod_a_reg <= prod_a_next;
            an_a_reg   <= an_a_next;
        end
    end

    always_comb
    begin
        logic [15:0] tq;
        logic [8:0]  ca_sum;
        logic [15:0] pq;
        tq = div255({8'd0, t_a_reg});
        ca_sum = {1'b0, a_a_reg} + {1'b0, tq[7:0]};
        ca_b_next = ca_sum[7:0];
        for (int c = 0; c < 3; c++) begin
            pq = div255({7'd0, prod_a_reg[c]});
            q1_b_next[c] = pq[8:0];
            ot_b_next[c] = {16'd0, o_a_reg[c]} * {8'd0, t_a_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.front[1])
        begin
            mode_b_reg <= mode_a_reg;
            oa_b_reg   <= oa_a_reg;
            ca_b_reg   <= ca_b_next;
            o_b_reg    <= o_a_reg;
            n_b_reg    <= n_a_reg;
            q1_b_reg   <= q1_b_next;
            ot_b_reg   <= ot_b_next;
            an_b_reg   <= an_a_reg;
        end
    end

    always_comb
    begin
        logic [7:0]  o;
        logic [7:0]  n;
        logic [8:0]  q1;
        logic [8:0]  sum;
        logic [8:0]  sa;
        logic [15:0] oq;
        logic [7:0]  dv;
        kind_t       kind;
        logic [7:0]  den;
        logic [DIV_W-1:0] num;
        div_in_next.alpha = (mode_b_reg == MODE_ALPHA && ca_b_reg != 8'd0) ? ca_b_reg : oa_b_reg;
        for (int c = 0; c < 3; c++) begin
            o    = o_b_reg[c];
            n    = n_b_reg[c];
            q1   = q1_b_reg[c];
            sum  = {1'b0, o} + {1'b0, n};
            sa   = {1'b0, o} + q1;
            oq   = div255(ot_b_reg[c]);
            kind = KIND_DIRECT;
            den  = 8'd1;
            num  = '0;
            case (mode_b_reg)
                MODE_SET:      dv = n;
                MODE_MULTIPLY: dv = q1[7:0];
                MODE_LIGHTEN:  dv = (o > n) ? o : n;
                MODE_DARKEN:   dv = (o < n) ? o : n;
                MODE_SCREEN:   dv = 8'd255 - q1[7:0];
                MODE_ADD:      dv = sum[8] ? 8'd255 : sum[7:0];
                MODE_ADDA:     dv = sa[8] ? 8'd255 : sa[7:0];
                MODE_BURN:     dv = (sum >= 9'd255) ? 8'(sum - 9'd255) : 8'd0;
                MODE_OVERLAY: begin
                    if (n <= 8'd128)
                        dv = q1[8] ? 8'd255 : q1[7:0];
                    else
                        dv = 8'd255 - q1[7:0];
                end
                MODE_DODGE: begin
                    dv = 8'd255;
                    if (o != 8'd255) begin
                        kind = KIND_DODGE;
                        den  = 8'd255 - o;
                        num  = {2'd0, n, 8'd0} - {10'd0, n};
                    end
                end
                MODE_CBURN: begin
                    dv = 8'd0;
                    if (n != 8'd0) begin
                        kind = KIND_CBURN;
                        den  = n;
                        num  = {2'd0, 8'd255 - o, 8'd0} - {10'd0, 8'd255 - o};
                    end
                end
                MODE_ALPHA: begin
                    dv = o;
                    if (ca_b_reg != 8'd0) begin
                        kind = KIND_ALPHA;
                        den  = ca_b_reg;
                        num  = {2'd0, an_b_reg[c]} + {2'd0, oq};
                    end
                end
                default:       dv = o;
            endcase
            div_in_next.ch[c].kind   = kind;
            div_in_next.ch[c].direct = dv;
            div_in_next.ch[c].den    = den;
            div_in_next.ch[c].rem    = 8'd0;
            div_in_next.ch[c].nq     = num;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.front[2])
        begin
            div_in_reg <= div_in_next;
        end
    end

    assign div_in = div_in_reg;

endmodule

// File: hw/rtl/bcb_div.sv
// Divider section: pipelined restoring division, three quotient bits per stage, per channel.
// Depends on bcb_pkg; sits between the front and back sections.
module bcb_div (
    input  logic              clk,
    input  bcb_pkg::bcb_adv_t adv,
    input  bcb_pkg::pix_div_t din,
    output bcb_pkg::pix_div_t dout
);
    import bcb_pkg::*;

    pix_div_t stage_reg [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv.div[0])
        begin
            stage_reg[0].alpha <= din.alpha;
            for (int c = 0; c < 3; c++) begin
                stage_reg[0].ch[c] <= div_step(din.ch[c]);
            end
        end
    end

    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
        always_ff @(posedge clk)
        begin
            if (adv.div[k])
            begin
                stage_reg[k].alpha <= stage_reg[k-1].alpha;
                for (int c = 0; c < 3; c++) begin
                    stage_reg[k].ch[c] <= div_step(stage_reg[k-1].ch[c]);
                end
            end
        end
    end

    assign dout = stage_reg[DIV_STAGES-1];

endmodule

// File: hw/rtl/bcb_back.sv
// Back section: forms each channel from the quotient or the direct value, then the output register.
// Depends on bcb_pkg.
module bcb_back (
    input  logic              clk,
    input  bcb_pkg::bcb_adv_t adv,
    input  bcb_pkg::pix_div_t din,
    output logic [7:0]        out_red,
    output logic [7:0]        out_green,
    output logic [7:0]        out_blue,
    output logic [7:0]        out_alpha
);
    import bcb_pkg::*;

    logic [2:0][7:0] chan_reg, chan_next;
    logic [7:0]      alpha_reg;

    always_comb
    begin
        logic [DIV_W-1:0] q;
        for (int c = 0; c < 3; c++) begin
            q = din.ch[c].nq;
            case (din.ch[c].kind)
                KIND_DODGE: chan_next[c] = (q > DIV_W'(255)) ? 8'd255 : q[7:0];
                KIND_CBURN: chan_next[c] = (q > DIV_W'(255)) ? 8'd0 : 8'd255 - q[7:0];
                KIND_ALPHA: chan_next[c] = q[7:0];
                default:    chan_next[c] = din.ch[c].direct;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.back)
        begin
            chan_reg  <= chan_next;
            alpha_reg <= din.alpha;
        end
    end

    assign out_red   = chan_reg[0];
    assign out_green = chan_reg[1];
    assign out_blue  = chan_reg[2];
    assign out_alpha = alpha_reg;

endmodule

// File: hw/rtl/background_color_blend_unit_top.sv
// Top level of the background color blend unit: handshake, stage valid bits, default mode register.
// Depends on bcb_pkg, bcb_front, bcb_div and bcb_back.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   opcode, blend_alpha, old_*, new_*
//   out      output     out_valid / out_stall out_red, out_green, out_blue, out_alpha
//   cfg      input      cfg_valid / cfg_ready cfg_data (default mode)
//
// A request passes through three front stages (mode decode, products, divide by 255),
// six divider stages of three quotient bits each, and the output register. One request
// per cycle is taken while in_stall is low. A stage loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stalled output holds only the stages behind it.
// Reset clears the valid bits and the default mode; cfg_ready is always high.
module background_color_blend_unit_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] opcode,
    input  logic [7:0] blend_alpha,
    input  logic [7:0] old_red,
    input  logic [7:0] old_green,
    input  logic [7:0] old_blue,
    input  logic [7:0] old_alpha,
    input  logic [7:0] new_red,
    input  logic [7:0] new_green,
    input  logic [7:0] new_blue,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data
);
    import bcb_pkg::*;

    logic [3:0]            default_mode_reg;
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] adv_vec;
    bcb_adv_t              adv;
    pix_div_t              div_in, div_out;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        adv_vec[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv_vec[k] = !valid_reg[k] || adv_vec[k+1];
        end
        valid_next[0] = adv_vec[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            valid_next[k] = adv_vec[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign adv.front = adv_vec[FRONT_STAGES-1:0];
    assign adv.div   = adv_vec[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES];
    assign adv.back  = adv_vec[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            default_mode_reg <= MODE_NONE;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_valid && cfg_ready)
            begin
                default_mode_reg <= cfg_data;
            end
        end
    end

    assign in_stall  = !adv_vec[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    bcb_front u_front (
        .clk          (clk),
        .adv          (adv),
        .default_mode (default_mode_reg),
        .opcode       (opcode),
        .blend_alpha  (blend_alpha),
        .old_red      (old_red),
        .old_green    (old_green),
        .old_blue     (old_blue),
        .old_alpha    (old_alpha),
        .new_red      (new_red),
        .new_green    (new_green),
        .new_blue     (new_blue),
        .div_in       (div_in)
    );

    bcb_div u_div (
        .clk  (clk),
        .adv  (adv),
        .din  (div_in),
        .dout (div_out)
    );

    bcb_back u_back (
        .clk       (clk),
        .adv       (adv),
        .din       (div_out),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

    // A free output slot must let the whole pipeline move.
    a_free_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output was free");

    // An empty output stage cannot hold anything back.
    a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output stage");

    // Backpressure at the input only comes from a full pipeline behind a stalled result.
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (valid_reg == '1) && out_stall)
        else $error("input stalled without a full pipeline");

endmodule
